// File: rtl/core/ktws_pkg.sv
// Shared types, widths and constants of the keystroke timing statistics block.
package ktws_pkg;

	localparam int WINDOW_DEF   = 100;
	localparam int CNT_W        = 7;
	localparam int GAP_W        = 24;
	localparam int SUM_W        = 31;
	localparam int SQ_W         = 55;
	localparam int NUM_W        = 62;
	localparam int DEN_W        = 14;
	localparam int ROOT_IN_W    = 64;
	localparam int ROOT_W       = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 24;

	localparam logic [GAP_W-1:0] GAP_MAX      = {GAP_W{1'b1}};
	localparam logic [27:0]      USEC_PER_SEC = 28'd1000000;

	localparam logic [9:0] KEY_LSHIFT = 10'd42;
	localparam logic [9:0] KEY_RSHIFT = 10'd54;
	localparam logic [9:0] KEY_CAPS   = 10'd58;
	localparam logic [1:0] VAL_PRESS  = 2'd1;

	typedef enum logic [2:0] {
		REG_MIN_SAMPLES = 3'd0,
		REG_VF_MEAN     = 3'd1,
		REG_VF_JITTER   = 3'd2,
		REG_F_MEAN      = 3'd3,
		REG_F_JITTER    = 3'd4,
		REG_MOD_MEAN    = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		CLS_NONE      = 3'd0,
		CLS_NORMAL    = 3'd1,
		CLS_MODERATE  = 3'd2,
		CLS_FAST      = 3'd3,
		CLS_VERY_FAST = 3'd4
	} timing_class_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ACC,
		ST_PROD,
		ST_MEAN,
		ST_VAR,
		ST_ROOT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        key_event;
		logic [9:0]  key_code;
		logic [1:0]  key_value;
		logic [31:0] time_sec;
		logic [19:0] time_usec;
	} in_item_t;

	typedef struct packed {
		logic             counted;
		logic [GAP_W-1:0] gap_us;
		logic [GAP_W-1:0] mean_us;
		logic [GAP_W-1:0] jitter_us;
		logic [CNT_W-1:0] fill_count;
		logic [31:0]      total_presses;
		logic [2:0]       timing_class;
	} out_item_t;

endpackage

// File: rtl/core/ktws_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ktws_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/ktws_div.sv
// Restoring divider, two quotient bits per cycle.
module ktws_div #(
	parameter int DW = 62,
	parameter int VW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int STEPS = 2;
	localparam int ITER  = (DW + STEPS - 1) / STEPS;
	localparam int CW    = $clog2(ITER + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] div_q;
	logic [VW-1:0] rem_n;
	logic [DW-1:0] quo_n;

	always_comb begin
		logic [VW:0] r;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int i = 0; i < STEPS; i++) begin
			r     = {rem_n, quo_n[DW-1]};
			quo_n = {quo_n[DW-2:0], 1'b0};
			if (r >= {1'b0, div_q}) begin
				r        = r - {1'b0, div_q};
				quo_n[0] = 1'b1;
			end
			rem_n = r[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ITER - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: rtl/core/ktws_sqrt.sv
// Floored integer square root, two result bits per cycle.
module ktws_sqrt #(
	parameter int IW = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [IW-1:0]   radicand,
	output logic            done,
	output logic [IW/2-1:0] root
);
	localparam int RW    = IW / 2;
	localparam int EW    = RW + 3;
	localparam int STEPS = 2;
	localparam int ITER  = RW / STEPS;
	localparam int CW    = $clog2(ITER + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] rad_q;
	logic [RW-1:0] root_q;
	logic [EW-1:0] rem_q;
	logic [IW-1:0] rad_n;
	logic [RW-1:0] root_n;
	logic [EW-1:0] rem_n;

	always_comb begin
		logic [EW-1:0] r;
		logic [EW-1:0] trial;
		rad_n  = rad_q;
		root_n = root_q;
		rem_n  = rem_q;
		for (int i = 0; i < STEPS; i++) begin
			r     = {rem_n[EW-3:0], rad_n[IW-1:IW-2]};
			rad_n = {rad_n[IW-3:0], 2'b00};
			trial = {1'b0, root_n, 2'b01};
			if (r >= trial) begin
				rem_n  = r - trial;
				root_n = {root_n[RW-2:0], 1'b1};
			end else begin
				rem_n  = r;
				root_n = {root_n[RW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ITER - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_n;
			root_q <= root_n;
			rem_q  <= rem_n;
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// File: rtl/core/keystroke_timing_window_stats.sv
// Keystroke timing statistics: sliding window of press gaps, mean, jitter and speed class.
//
// Each input request is one keyboard event; each produces exactly one result request.
// A press (key event, value 1) counts unless it is shift (42, 54) or caps lock (58).
// From the second counted press on, the gap to the previous press in microseconds
// (clamped at 0, saturated at 16777215) replaces the oldest entry of a WINDOW-deep
// gap memory once full. Running sum and sum of squares are kept in registers and
// corrected with the evicted entry through a read-modify-write of the gap memory
// (read one cycle, write back the next). The mean comes from a shared two-bit-per-cycle
// restoring divider, the sample variance from a second pass of the same divider on
// n*sumsq - sum^2 over n*(n-1), and the jitter from a two-bit-per-cycle square root.
// After acceptance an event passes through the memory read, accumulation and products,
// two divider passes and the square root, and then loads the output register. One
// event is worked at a time; the next request is taken the cycle after the result is
// loaded into the output register, which may still be waiting for the sink; a stalled
// sink holds the block in its last state.
// Configuration registers (index 0..5) are written through the cfg channel, which is
// always ready; writes to other indexes are dropped. No clearing pass is needed
// after reset: the evicted entry is used only once the window is full, when every
// entry has been written.
module keystroke_timing_window_stats #(
	parameter int WINDOW = ktws_pkg::WINDOW_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  ktws_pkg::in_item_t                     in_item,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output ktws_pkg::out_item_t                    out_item,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ktws_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ktws_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import ktws_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW);
	localparam logic [CNT_W-1:0]  WIN_CNT  = CNT_W'(WINDOW);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

	// configuration
	logic [CNT_W-1:0] min_samples_q;
	logic [GAP_W-1:0] vf_mean_q, vf_jitter_q, f_mean_q, f_jitter_q, mod_mean_q;

	// window state
	state_t            state_q, state_n;
	logic [31:0]       last_sec_q;
	logic [19:0]       last_usec_q;
	logic              have_last_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  filled_q;
	logic [31:0]       press_total_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sq_q;

	// per-event work registers
	logic             counted_q;
	logic             store_q;
	logic [GAP_W-1:0] gap_q;
	logic [GAP_W-1:0] old_q;
	logic [2*GAP_W-1:0] old_sq_s1, new_sq_s1;
	logic [NUM_W-1:0] prod_a_s2, prod_b_s2;
	logic [DEN_W-1:0] den_s2;
	logic [GAP_W-1:0] mean_q, jitter_q;

	logic      out_valid_q;
	out_item_t out_q;

	// control decode
	logic in_acc;
	logic ram_we;
	logic div_start, sqrt_start;
	logic out_load;
	logic [NUM_W-1:0] div_dividend;
	logic [DEN_W-1:0] div_divisor;
	logic             div_done, sqrt_done;
	logic [NUM_W-1:0] div_quo;
	logic [ROOT_W-1:0] root;
	logic [GAP_W-1:0]  ram_rdata;

	// event decode and gap calculation
	logic        is_counted;
	logic signed [32:0] sec_diff;
	logic signed [20:0] usec_diff;
	logic signed [27:0] d_full;
	logic [GAP_W-1:0]   gap_now;

	assign in_acc = in_valid && in_ready;
	assign is_counted = in_item.key_event && (in_item.key_value == VAL_PRESS)
		&& (in_item.key_code != KEY_LSHIFT) && (in_item.key_code != KEY_RSHIFT)
		&& (in_item.key_code != KEY_CAPS);

	assign sec_diff  = $signed({1'b0, in_item.time_sec}) - $signed({1'b0, last_sec_q});
	assign usec_diff = $signed({1'b0, in_item.time_usec}) - $signed({1'b0, last_usec_q});

	// only a seconds difference in [-1, 17] can land inside the gap range
	always_comb begin
		d_full  = $signed(sec_diff[5:0]) * $signed(USEC_PER_SEC) + 28'(usec_diff);
		gap_now = '0;
		if (sec_diff > 33'sd17) begin
			gap_now = GAP_MAX;
		end else if (sec_diff < -33'sd2) begin
			gap_now = '0;
		end else if (d_full < 0) begin
			gap_now = '0;
		end else if (d_full > $signed({4'b0, GAP_MAX})) begin
			gap_now = GAP_MAX;
		end else begin
			gap_now = d_full[GAP_W-1:0];
		end
	end

	// gap memory
	ktws_ram #(
		.WIDTH(GAP_W),
		.DEPTH(WINDOW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(gap_q),
		.raddr(slot_q),
		.rdata(ram_rdata)
	);

	ktws_div #(
		.DW(NUM_W),
		.VW(DEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quo)
	);

	ktws_sqrt #(
		.IW(ROOT_IN_W)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(ROOT_IN_W'(div_quo)),
		.done    (sqrt_done),
		.root    (root)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_n = ST_READ;
			ST_READ: state_n = ST_ACC;
			ST_ACC:  state_n = ST_PROD;
			ST_PROD: state_n = ST_MEAN;
			ST_MEAN: if (div_done) state_n = ST_VAR;
			ST_VAR:  if (div_done) state_n = ST_ROOT;
			ST_ROOT: if (sqrt_done) state_n = ST_OUT;
			ST_OUT:  if (!out_valid_q || out_ready) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready     = 1'b0;
		ram_we       = 1'b0;
		div_start    = 1'b0;
		sqrt_start   = 1'b0;
		out_load     = 1'b0;
		div_dividend = NUM_W'(sum_q);
		div_divisor  = DEN_W'(filled_q);
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_READ: ram_we = store_q;
			ST_ACC:  ;
			ST_PROD: div_start = 1'b1;
			ST_MEAN: begin
				div_start    = div_done;
				div_dividend = prod_a_s2 - prod_b_s2;
				div_divisor  = den_s2;
			end
			ST_VAR:  sqrt_start = div_done;
			ST_ROOT: ;
			ST_OUT:  out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			last_sec_q    <= '0;
			last_usec_q   <= '0;
			have_last_q   <= 1'b0;
			slot_q        <= '0;
			filled_q      <= '0;
			press_total_q <= '0;
			sum_q         <= '0;
			sq_q          <= '0;
			out_valid_q   <= 1'b0;
			min_samples_q <= CNT_W'(10);
			vf_mean_q     <= GAP_W'(5000);
			vf_jitter_q   <= GAP_W'(10000);
			f_mean_q      <= GAP_W'(15000);
			f_jitter_q    <= GAP_W'(100000);
			mod_mean_q    <= GAP_W'(50000);
		end else begin
			state_q <= state_n;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MIN_SAMPLES: min_samples_q <= cfg_data[CNT_W-1:0];
					REG_VF_MEAN:     vf_mean_q     <= cfg_data;
					REG_VF_JITTER:   vf_jitter_q   <= cfg_data;
					REG_F_MEAN:      f_mean_q      <= cfg_data;
					REG_F_JITTER:    f_jitter_q    <= cfg_data;
					REG_MOD_MEAN:    mod_mean_q    <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc && is_counted) begin
				last_sec_q    <= in_item.time_sec;
				last_usec_q   <= in_item.time_usec;
				have_last_q   <= 1'b1;
				press_total_q <= press_total_q + 1'b1;
			end
			if (state_q == ST_ACC && store_q) begin
				sum_q <= sum_q - SUM_W'(old_q) + SUM_W'(gap_q);
				sq_q  <= sq_q - SQ_W'(old_sq_s1) + SQ_W'(new_sq_s1);
				if (filled_q != WIN_CNT) begin
					filled_q <= filled_q + 1'b1;
				end
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		logic [GAP_W-1:0] old_v;
		old_v = (filled_q == WIN_CNT) ? ram_rdata : '0;
		if (in_acc) begin
			counted_q <= is_counted;
			store_q   <= is_counted && have_last_q;
			gap_q     <= (is_counted && have_last_q) ? gap_now : '0;
		end
		if (state_q == ST_READ) begin
			old_q     <= old_v;
			old_sq_s1 <= old_v * old_v;
			new_sq_s1 <= gap_q * gap_q;
		end
		if (state_q == ST_PROD) begin
			prod_a_s2 <= NUM_W'(filled_q) * NUM_W'(sq_q);
			prod_b_s2 <= NUM_W'(sum_q) * NUM_W'(sum_q);
			den_s2    <= DEN_W'(filled_q) * DEN_W'(filled_q - 1'b1);
		end
		if (state_q == ST_MEAN && div_done) begin
			mean_q <= (filled_q == '0) ? '0 : div_quo[GAP_W-1:0];
		end
		if (state_q == ST_ROOT && sqrt_done) begin
			if (filled_q < CNT_W'(2)) begin
				jitter_q <= '0;
			end else if (root > ROOT_W'(GAP_MAX)) begin
				jitter_q <= GAP_MAX;
			end else begin
				jitter_q <= root[GAP_W-1:0];
			end
		end
		if (out_load) begin
			out_q.counted       <= counted_q;
			out_q.gap_us        <= gap_q;
			out_q.mean_us       <= mean_q;
			out_q.jitter_us     <= jitter_q;
			out_q.fill_count    <= filled_q;
			out_q.total_presses <= press_total_q;
			if (filled_q < min_samples_q) begin
				out_q.timing_class <= CLS_NONE;
			end else if (mean_q < vf_mean_q && jitter_q < vf_jitter_q) begin
				out_q.timing_class <= CLS_VERY_FAST;
			end else if (mean_q < f_mean_q && jitter_q < f_jitter_q) begin
				out_q.timing_class <= CLS_FAST;
			end else if (mean_q < mod_mean_q) begin
				out_q.timing_class <= CLS_MODERATE;
			end else begin
				out_q.timing_class <= CLS_NORMAL;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
	// window fill never passes its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= WIN_CNT) else $error("window fill above depth");

	// write pointer stays inside the memory
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= LAST_SLOT) else $error("slot pointer out of range");

	// an accepted request always starts the memory read
	a_acc_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_READ) else $error("accept did not start read");

	// counted press bumps the total by exactly one
	a_press_inc: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_counted |=> press_total_q == $past(press_total_q) + 32'd1)
		else $error("press total not incremented");

	// memory written only when a gap is stored
	a_we_store: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> store_q && state_q == ST_READ) else $error("stray window write");
`endif
endmodule

// File: tb/keystroke_timing_window_stats_tb.sv
// Testbench for keystroke_timing_window_stats: gap window statistics against an in-bench model.
`timescale 1ns / 1ps
module keystroke_timing_window_stats_tb;
	import ktws_pkg::*;

	localparam int         N_WIN        = 100;
	localparam int         RAND_EVENTS  = 1300;
	localparam int         PHASES       = 6;
	localparam int         CYCLE_LIMIT  = 3000000;
	localparam int         DRAIN_CYCLES = 200;
	localparam logic [2:0] REG_SPARE_A  = 3'd6;	// no register behind these
	localparam logic [2:0] REG_SPARE_B  = 3'd7;
	localparam logic [9:0] KEY_A        = 10'd30;

	typedef struct {
		in_item_t  ev;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	keystroke_timing_window_stats uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Model copy of the configuration registers
	logic [6:0]  m_min_samples;
	logic [23:0] m_vf_mean, m_vf_jit, m_f_mean, m_f_jit, m_mod_mean;

	// Model copy of the block state
	logic [31:0]       m_last_sec;
	logic [19:0]       m_last_usec;
	bit                m_have_last;
	logic [23:0]       m_gaps[N_WIN];
	int unsigned       m_slot, m_filled;
	logic [31:0]       m_presses;
	longint unsigned   m_sum, m_sqsum;

	out_item_t stats_q[$];	// expected result of every accepted request, oldest first
	int        mismatches = 0;
	bit        timed_out = 0;
	longint    cycles = 0;

	// Side info travelling with the input payload: typed expectation for directed rows
	bit        cur_typed = 0;
	out_item_t cur_want = '0;

	// Sink stall and source idle control
	bit        sink_no_stall = 0;
	int        sink_hold = 0;
	bit        src_no_idle = 0;

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Advance the model by one event and return the statistics it reports
	function automatic out_item_t window_stats(in_item_t ev);
		out_item_t o = '0;
		logic [23:0] gap = '0;
		longint d;
		longint unsigned old, n, num, sd;
		logic [23:0] mean = '0, jit = '0;
		bit cnt;
		cnt = ev.key_event && ev.key_value == VAL_PRESS && ev.key_code != KEY_LSHIFT
			&& ev.key_code != KEY_RSHIFT && ev.key_code != KEY_CAPS;
		if (cnt) begin
			if (m_have_last) begin
				d = (longint'(ev.time_sec) - longint'(m_last_sec)) * 1000000
					+ (longint'(ev.time_usec) - longint'(m_last_usec));
				if (d < 0) gap = '0;
				else if (d > longint'(GAP_MAX)) gap = GAP_MAX;
				else gap = d[23:0];
				if (m_slot >= N_WIN) m_slot = 0;
				if (m_filled >= N_WIN) begin
					old = m_gaps[m_slot];
					m_sum -= old;
					m_sqsum -= old * old;
				end else begin
					m_filled++;
				end
				m_gaps[m_slot] = gap;
				m_sum += gap;
				m_sqsum += longint'(gap) * longint'(gap);
				m_slot = (m_slot + 1 >= N_WIN) ? 0 : m_slot + 1;
			end
			m_last_sec = ev.time_sec;
			m_last_usec = ev.time_usec;
			m_have_last = 1;
			m_presses++;
		end
		n = m_filled;
		if (n > 0) mean = (m_sum / n) > GAP_MAX ? GAP_MAX : 24'(m_sum / n);
		if (n >= 2) begin
			num = n * m_sqsum - m_sum * m_sum;
			sd = floor_root(num / (n * (n - 1)));
			jit = sd > GAP_MAX ? GAP_MAX : sd[23:0];
		end
		o.counted = cnt;
		o.gap_us = gap;
		o.mean_us = mean;
		o.jitter_us = jit;
		o.fill_count = m_filled[6:0];
		o.total_presses = m_presses;
		if (m_filled < m_min_samples) o.timing_class = CLS_NONE;
		else if (mean < m_vf_mean && jit < m_vf_jit) o.timing_class = CLS_VERY_FAST;
		else if (mean < m_f_mean && jit < m_f_jit) o.timing_class = CLS_FAST;
		else if (mean < m_mod_mean) o.timing_class = CLS_MODERATE;
		else o.timing_class = CLS_NORMAL;
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 20);
		return $urandom_range(30, 200);
	endfunction

	always @(posedge clk) cycles <= cycles + 1;

	// Sink: random stalls, with stretches of none
	always @(posedge clk) begin
		if (sink_no_stall) begin
			out_ready <= 1'b1;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			out_ready <= 1'b0;
		end else begin
			sink_hold <= pick_gap();
			out_ready <= 1'b1;
		end
	end

	// Monitor: predict on request acceptance, compare on result acceptance
	always @(posedge clk) begin
		out_item_t pred, want;
		bit bad;
		if (arst_n && in_valid && in_ready) begin
			pred = window_stats(in_item);
			stats_q.push_back(cur_typed ? cur_want : pred);
		end
		if (arst_n && out_valid && out_ready) begin
			if (stats_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", out_item);
			end else begin
				want = stats_q.pop_front();
				bad = out_item.counted !== want.counted
					|| out_item.gap_us !== want.gap_us
					|| out_item.mean_us !== want.mean_us
					|| out_item.jitter_us !== want.jitter_us
					|| out_item.fill_count !== want.fill_count
					|| out_item.total_presses !== want.total_presses
					|| out_item.timing_class !== want.timing_class;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %p got %p", want, out_item);
				end
			end
		end
	end

	// Send one event; valid stays high across back-to-back requests
	task automatic send_event(in_item_t ev, bit typed, out_item_t want);
		int gap;
		gap = src_no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= ev;
		cur_typed <= typed;
		cur_want <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		cur_typed <= 1'b0;
		while (stats_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all six registers plus the two unused indexes, back to back
	task automatic write_regs(logic [23:0] v[6]);
		logic [2:0] idx[8];
		logic [23:0] dat;
		idx = '{REG_MIN_SAMPLES, REG_SPARE_A, REG_VF_MEAN, REG_VF_JITTER,
			REG_F_MEAN, REG_F_JITTER, REG_MOD_MEAN, REG_SPARE_B};
		foreach (idx[k]) begin
			if (idx[k] == REG_SPARE_A || idx[k] == REG_SPARE_B) dat = 24'($urandom);
			else dat = v[idx[k]];
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= dat;
			do @(posedge clk); while (!cfg_ready);
			case (idx[k])
				REG_MIN_SAMPLES: m_min_samples = dat[6:0];
				REG_VF_MEAN:     m_vf_mean = dat;
				REG_VF_JITTER:   m_vf_jit = dat;
				REG_F_MEAN:      m_f_mean = dat;
				REG_F_JITTER:    m_f_jit = dat;
				REG_MOD_MEAN:    m_mod_mean = dat;
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t mk(bit e, logic [9:0] c, logic [1:0] v,
			logic [31:0] s, logic [19:0] u);
		in_item_t it;
		it.key_event = e; it.key_code = c; it.key_value = v;
		it.time_sec = s; it.time_usec = u;
		return it;
	endfunction

	function automatic out_item_t res(bit c, logic [23:0] g, logic [23:0] m,
			logic [23:0] j, logic [6:0] n, logic [31:0] t, timing_class_t k);
		out_item_t o;
		o.counted = c; o.gap_us = g; o.mean_us = m; o.jitter_us = j;
		o.fill_count = n; o.total_presses = t; o.timing_class = k;
		return o;
	endfunction

	initial begin
		dir_row_t rows[$];
		logic [23:0] cfgs[PHASES][6];
		longint t_us;
		int base, spread, r;
		in_item_t ev;
		out_item_t none;

		none = '0;
		m_min_samples = 7'd10; m_vf_mean = 24'd5000; m_vf_jit = 24'd10000;
		m_f_mean = 24'd15000; m_f_jit = 24'd100000; m_mod_mean = 24'd50000;
		m_last_sec = '0; m_last_usec = '0; m_have_last = 0;
		foreach (m_gaps[i]) m_gaps[i] = '0;
		m_slot = 0; m_filled = 0; m_presses = '0; m_sum = 0; m_sqsum = 0;

		// Directed rows; typed expectations only where obvious
		rows.push_back('{mk(1, KEY_A, 2'd0, 0, 0), 1, res(0, 0, 0, 0, 0, 0, CLS_NONE)});
		rows.push_back('{mk(1, KEY_A, VAL_PRESS, 0, 0), 1, res(0, 0, 0, 0, 0, 1, CLS_NONE)});
		rows[$].want.counted = 1'b1;
		rows.push_back('{mk(1, KEY_LSHIFT, VAL_PRESS, 0, 9), 1, res(0, 0, 0, 0, 0, 1, CLS_NONE)});
		rows.push_back('{mk(1, KEY_RSHIFT, VAL_PRESS, 0, 9), 1, res(0, 0, 0, 0, 0, 1, CLS_NONE)});
		rows.push_back('{mk(1, KEY_CAPS, VAL_PRESS, 0, 9), 1, res(0, 0, 0, 0, 0, 1, CLS_NONE)});
		rows.push_back('{mk(1, KEY_A, 2'd2, 0, 9), 1, res(0, 0, 0, 0, 0, 1, CLS_NONE)});
		// value 3 is not a press
		rows.push_back('{mk(1, KEY_A, 2'd3, 0, 9), 1, res(0, 0, 0, 0, 0, 1, CLS_NONE)});
		rows.push_back('{mk(0, KEY_A, VAL_PRESS, 0, 9), 1, res(0, 0, 0, 0, 0, 1, CLS_NONE)});
		// one second later: first gap
		rows.push_back('{mk(1, KEY_A, VAL_PRESS, 1, 0), 1,
			res(1, 1000000, 1000000, 0, 1, 2, CLS_NONE)});
		// going back in time clamps to zero
		rows.push_back('{mk(1, KEY_A, VAL_PRESS, 0, 5), 1,
			res(1, 0, 500000, 707106, 2, 3, CLS_NONE)});
		// huge gap saturates; then same stamp, wide codes, micros past one second
		rows.push_back('{mk(1, 10'd1023, VAL_PRESS, 32'hFFFFFFFF, 20'hFFFFF), 0, none});
		rows.push_back('{mk(1, 10'd1023, VAL_PRESS, 32'hFFFFFFFF, 20'hFFFFF), 0, none});
		rows.push_back('{mk(1, 10'd0, VAL_PRESS, 0, 0), 0, none});
		rows.push_back('{mk(1, 10'd767, VAL_PRESS, 1, 20'hFFFFF), 0, none});
		rows.push_back('{mk(1, 10'd512, VAL_PRESS, 2, 20'h80000), 0, none});
		rows.push_back('{mk(1, 10'd341, 2'd0, 32'h55555555, 20'h55555), 0, none});
		rows.push_back('{mk(1, 10'd682, VAL_PRESS, 2, 20'h80100), 0, none});
		rows.push_back('{mk(1, 10'd31, VAL_PRESS, 2, 20'h80200), 0, none});

		// Register settings per random phase: extremes included
		cfgs[0] = '{7'd0,   24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
		cfgs[1] = '{7'd127, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
		cfgs[2] = '{7'd1,   24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
		cfgs[3] = '{7'd100, 24'd5000, 24'd10000, 24'd15000, 24'd100000, 24'd50000};
		cfgs[4] = '{7'd2,   24'd8000, 24'd3000, 24'd20000, 24'd30000, 24'd60000};
		cfgs[5] = '{7'd10,  24'd4000, 24'd2500, 24'd14000, 24'd9000, 24'd45000};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (rows[i]) send_event(rows[i].ev, rows[i].typed, rows[i].want);
		wait_idle();

		t_us = 64'd5000000;
		for (int p = 0; p < PHASES; p++) begin
			write_regs(cfgs[p]);
			@(posedge clk);
			sink_no_stall = (p == 2);
			src_no_idle = (p == 4);
			base = 3000;
			spread = 2000;
			for (int i = 0; i < RAND_EVENTS / PHASES; i++) begin
				// typing speed drifts across the class bands
				if (i % 40 == 0) begin
					case ($urandom_range(0, 4))
						0: begin base = 1000;   spread = 1500;   end
						1: begin base = 4000;   spread = 20000;  end
						2: begin base = 10000;  spread = 6000;   end
						3: begin base = 30000;  spread = 40000;  end
						default: begin base = 80000; spread = 300000; end
					endcase
				end
				r = $urandom_range(0, 99);
				if (r < 80) begin
					t_us += base + $urandom_range(0, spread);
					ev = mk(1, 10'($urandom_range(0, 1023)), VAL_PRESS,
						32'(t_us / 1000000), 20'(t_us % 1000000));
					if (ev.key_code == KEY_LSHIFT || ev.key_code == KEY_RSHIFT
							|| ev.key_code == KEY_CAPS)
						ev.key_code = KEY_A;
				end else if (r < 83) begin
					t_us -= $urandom_range(1, 500000);
					if (t_us < 0) t_us = 0;
					ev = mk(1, KEY_A, VAL_PRESS, 32'(t_us / 1000000), 20'(t_us % 1000000));
				end else if (r < 85) begin
					t_us += 64'd20000000 + $urandom_range(0, 1000000);
					ev = mk(1, KEY_A, VAL_PRESS, 32'(t_us / 1000000), 20'(t_us % 1000000));
				end else if (r < 87) begin
					ev = mk(1, KEY_A, VAL_PRESS, 32'(t_us / 1000000),
						20'($urandom_range(1000000, 1048575)));
				end else begin
					ev = mk($urandom_range(0, 1), 10'($urandom_range(0, 1023)),
						2'($urandom_range(0, 3)), 32'($urandom), 20'($urandom));
					r = $urandom_range(0, 3);
					if (r == 0) ev.key_code = KEY_LSHIFT;
					else if (r == 1) ev.key_code = KEY_RSHIFT;
					else if (r == 2) ev.key_code = KEY_CAPS;
				end
				send_event(ev, 1'b0, none);
			end
			wait_idle();
		end

		if (mismatches == 0 && !timed_out)
			$display("PASS keystroke_timing_window_stats");
		else
			$display("FAIL keystroke_timing_window_stats");
		$finish;
	end

	// Watchdog
	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL keystroke_timing_window_stats");
			$finish;
		end
	end

endmodule
